### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/htw_pkg.sv
// Shared types and constants of the hierarchical timing wheel.
// No dependencies; used by the core, the divider and the checker.
package htw_pkg;

    // Default sizes of the pool and the wheel levels.
    localparam int POOL_SIZE_DEF        = 32;
    localparam int LEVEL1_BITS_DEF      = 8;
    localparam int UPPER_LEVEL_BITS_DEF = 6;

    // Tick period register.
    localparam int             PERIOD_W   = 10;
    localparam logic [9:0]     PERIOD_RST = 10'd10;

    // Width of the millisecond and tick words.
    localparam int TIME_W = 32;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_SET   = 2'd1,
        ACT_KILL  = 2'd2,
        ACT_QUERY = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        KIND_FIRED = 3'd0,
        KIND_SET   = 3'd1,
        KIND_FULL  = 3'd2,
        KIND_ALIVE = 3'd3,
        KIND_KILL  = 3'd4,
        KIND_TICK  = 3'd5
    } t_kind;

    // Request to the shared divider.
    typedef struct packed {
        logic                start;
        logic [TIME_W-1:0]   dividend;
        logic [PERIOD_W-1:0] divisor;
    } t_div_req;

endpackage

### rtl/core/htw_div.sv
// Restoring divider that turns a millisecond value into a tick count, one bit a cycle.
// Depends on htw_pkg for the request struct and the word widths.
module htw_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  htw_pkg::t_div_req          i_req,
    output logic                       o_done,
    output logic [htw_pkg::TIME_W-1:0] o_quotient
);
    import htw_pkg::*;

    localparam int CW = $clog2(TIME_W);

    logic                r_busy;
    logic                r_done;
    logic [CW-1:0]       r_cnt;
    logic [TIME_W-1:0]   r_quo;
    logic [PERIOD_W-1:0] r_rem;
    logic [PERIOD_W-1:0] r_div;

    logic [PERIOD_W:0]   rem_sh;
    logic [PERIOD_W:0]   diff;
    logic                ge;

    // One trial subtraction per cycle.
    always_comb begin
        rem_sh = {r_rem, r_quo[TIME_W-1]};
        diff   = rem_sh - {1'b0, r_div};
        ge     = (rem_sh >= {1'b0, r_div});
    end

    // Control: busy flag, bit counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(TIME_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend shifts out as the quotient shifts in.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[TIME_W-2:0], ge};
            r_rem <= ge ? diff[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### rtl/core/hierarchical_timing_wheel_core.sv
// Five-level timing wheel of periodic timers; depends on htw_pkg and htw_div.
// Kill, query and pool full go straight to their result; a set runs one divide for its
// expiry, the first set another before it (it also divides now_ms); a tick checks the upper
// slots when the level-one index wraps, moves timers and fires timers, one divide per fired timer.
// One item at a time; input is stalled until the last result item is loaded.
// Reset: synchronous; a clearing pass over all SLOT_COUNT slots empties the slot memory first.
module hierarchical_timing_wheel_core #(
    parameter int POOL_SIZE        = htw_pkg::POOL_SIZE_DEF,
    parameter int LEVEL1_BITS      = htw_pkg::LEVEL1_BITS_DEF,
    parameter int UPPER_LEVEL_BITS = htw_pkg::UPPER_LEVEL_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [9:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_event_id,
    input  logic [30:0]        i_interval_ms,
    input  logic [31:0]        i_now_ms,
    input  logic [31:0]        i_delay_ms,
    input  logic [4:0]         i_timer_handle,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_kind,
    output logic signed [31:0] o_fired_event,
    output logic [4:0]         o_handle_out,
    output logic               o_alive,
    output logic               o_last
);
    import htw_pkg::*;

    localparam int IW         = $clog2(POOL_SIZE);
    localparam int L1_SIZE    = 1 << LEVEL1_BITS;
    localparam int UP_SIZE    = 1 << UPPER_LEVEL_BITS;
    localparam int SLOT_COUNT = L1_SIZE + 4 * UP_SIZE;
    localparam int SW         = $clog2(SLOT_COUNT);
    localparam int ST_W       = 1 + 2 * IW;
    localparam int SH0        = LEVEL1_BITS;
    localparam int SH1        = LEVEL1_BITS + UPPER_LEVEL_BITS;
    localparam int SH2        = LEVEL1_BITS + 2 * UPPER_LEVEL_BITS;
    localparam int SH3        = LEVEL1_BITS + 3 * UPPER_LEVEL_BITS;
    localparam int BASE0      = L1_SIZE;
    localparam int BASE1      = L1_SIZE + UP_SIZE;
    localparam int BASE2      = L1_SIZE + 2 * UP_SIZE;
    localparam int BASE3      = L1_SIZE + 3 * UP_SIZE;

    typedef enum logic [15:0] {
        S_CLR   = 16'h0001,
        S_IDLE  = 16'h0002,
        S_DIVC  = 16'h0004,
        S_SETA  = 16'h0008,
        S_DIVE  = 16'h0010,
        S_PLACE = 16'h0020,
        S_PLRD  = 16'h0040,
        S_CSEL  = 16'h0080,
        S_CRD   = 16'h0100,
        S_L1    = 16'h0200,
        S_L1RD  = 16'h0400,
        S_WRD   = 16'h0800,
        S_WUSE  = 16'h1000,
        S_DIVF  = 16'h2000,
        S_NEXT  = 16'h4000,
        S_RESP  = 16'h8000
    } t_state;

    // Control registers.
    t_state            r_state, n_state;
    logic [9:0]        r_period;
    logic              r_enabled;
    logic [31:0]       r_cur;
    logic [SW-1:0]     r_clr;
    logic              r_used [POOL_SIZE];
    logic              r_del  [POOL_SIZE];
    logic              r_ov;

    // Working registers of the sequencer.
    logic [30:0]       r_interval;
    logic [31:0]       r_event;
    logic [31:0]       r_dl;
    logic [31:0]       r_exp;
    logic [IW-1:0]     r_e;
    logic [IW-1:0]     r_tail;
    logic [IW-1:0]     r_nx;
    logic [IW-1:0]     r_cnt;
    logic              r_end;
    logic              r_fire;
    logic              r_ret_set;
    logic [1:0]        r_lv;
    logic              r_knz;
    logic [SW-1:0]     r_slot;
    t_kind             r_resp_kind;
    logic [4:0]        r_resp_handle;
    logic              r_resp_alive;

    // Output registers.
    t_kind             r_okind;
    logic [31:0]       r_oev;
    logic [4:0]        r_ohandle;
    logic              r_oalive;

    // Memories and their registered read data.
    logic [ST_W-1:0]   m_slot [SLOT_COUNT];
    logic [IW-1:0]     m_link [POOL_SIZE];
    logic [31:0]       m_exp  [POOL_SIZE];
    logic [31:0]       m_dl   [POOL_SIZE];
    logic [31:0]       m_ev   [POOL_SIZE];
    logic [30:0]       m_per  [POOL_SIZE];
    logic [ST_W-1:0]   r_slot_rd;
    logic [IW-1:0]     r_rd_link;
    logic [31:0]       r_rd_exp;
    logic [31:0]       r_rd_dl;
    logic [31:0]       r_rd_ev;
    logic [30:0]       r_rd_per;

    // Combinational helpers.
    logic              accept;
    logic              free_found;
    logic [IW-1:0]     free_idx;
    logic              h_ok;
    logic [IW-1:0]     h_idx;
    logic [9:0]        eff_period;
    logic [31:0]       set_sum;
    logic [31:0]       fire_dl;
    logic [SW-1:0]     plc_slot;
    logic [SW-1:0]     csel_slot;
    logic              csel_knz;
    logic [SW-1:0]     l1_slot;
    logic [SW-1:0]     slot_raddr;
    logic              slot_we;
    logic [SW-1:0]     slot_waddr;
    logic [ST_W-1:0]   slot_wdata;
    logic              sr_valid;
    logic [IW-1:0]     sr_head;
    logic [IW-1:0]     sr_tail;
    logic              walk_done;
    logic              casc_done;
    logic              emit_req;
    t_kind             emit_kind;
    logic [31:0]       emit_ev;
    logic [4:0]        emit_handle;
    logic              emit_alive;
    logic              out_load;
    t_div_req          div_req;
    logic              div_done;
    logic [31:0]       div_q;

    // Slot chosen for a timer from its expiry tick and the current tick.
    function automatic logic [SW-1:0] place_slot(logic [31:0] nxt, logic [31:0] cur);
        logic [31:0]   d;
        logic [63:0]   wd;
        logic [63:0]   wn;
        logic [63:0]   t;
        logic [SW-1:0] s;
        d  = nxt - cur;
        wd = {32'd0, d};
        wn = {32'd0, nxt};
        if (d[31]) begin
            s = SW'(cur[LEVEL1_BITS-1:0]);
        end else if (d < 32'(L1_SIZE)) begin
            s = SW'(nxt[LEVEL1_BITS-1:0]);
        end else if ((wd >> SH1) == 64'd0) begin
            t = wn >> SH0;
            s = SW'(BASE0) + SW'(t[UPPER_LEVEL_BITS-1:0]);
        end else if ((wd >> SH2) == 64'd0) begin
            t = wn >> SH1;
            s = SW'(BASE1) + SW'(t[UPPER_LEVEL_BITS-1:0]);
        end else if ((wd >> SH3) == 64'd0) begin
            t = wn >> SH2;
            s = SW'(BASE2) + SW'(t[UPPER_LEVEL_BITS-1:0]);
        end else begin
            t = wn >> SH3;
            s = SW'(BASE3) + SW'(t[UPPER_LEVEL_BITS-1:0]);
        end
        return s;
    endfunction

    // Lowest free pool entry.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = POOL_SIZE - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    // Handle check, period and arithmetic shared by several states.
    always_comb begin
        logic [63:0] wc;
        logic [63:0] t;
        h_ok       = (32'(i_timer_handle) < 32'(POOL_SIZE));
        h_idx      = IW'(i_timer_handle);
        eff_period = (r_period == 10'd0) ? 10'd1 : r_period;
        set_sum    = r_dl + {1'b0, r_interval};
        fire_dl    = r_rd_dl + {1'b0, r_rd_per};
        plc_slot   = place_slot(r_exp, r_cur);
        l1_slot    = SW'(r_cur[LEVEL1_BITS-1:0]);
        wc         = {32'd0, r_cur};
        case (r_lv)
            2'd0: begin
                t         = wc >> SH0;
                csel_slot = SW'(BASE0) + SW'(t[UPPER_LEVEL_BITS-1:0]);
            end
            2'd1: begin
                t         = wc >> SH1;
                csel_slot = SW'(BASE1) + SW'(t[UPPER_LEVEL_BITS-1:0]);
            end
            2'd2: begin
                t         = wc >> SH2;
                csel_slot = SW'(BASE2) + SW'(t[UPPER_LEVEL_BITS-1:0]);
            end
            default: begin
                t         = wc >> SH3;
                csel_slot = SW'(BASE3) + SW'(t[UPPER_LEVEL_BITS-1:0]);
            end
        endcase
        csel_knz = (t[UPPER_LEVEL_BITS-1:0] != '0);
    end

    assign sr_valid = r_slot_rd[ST_W-1];
    assign sr_head  = r_slot_rd[2*IW-1:IW];
    assign sr_tail  = r_slot_rd[IW-1:0];

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign walk_done = r_end || (r_cnt == IW'(POOL_SIZE - 1));
    assign casc_done = r_knz || (r_lv == 2'd3);

    // Result selection and the output load.
    always_comb begin
        emit_req    = 1'b0;
        emit_kind   = r_resp_kind;
        emit_ev     = '0;
        emit_handle = r_resp_handle;
        emit_alive  = r_resp_alive;
        if (r_state == S_RESP) begin
            emit_req = 1'b1;
        end else if ((r_state == S_WUSE) && r_fire && !r_del[r_e]) begin
            emit_req    = 1'b1;
            emit_kind   = KIND_FIRED;
            emit_ev     = r_rd_ev;
            emit_handle = 5'(r_e);
            emit_alive  = 1'b0;
        end
        out_load = emit_req && (!r_ov || !i_out_stall);
    end

    // Divider requests: current tick at the first set, then each new expiry.
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = i_now_ms;
        div_req.divisor  = eff_period;
        if (accept && (t_action'(i_action) == ACT_SET) && free_found && !r_enabled) begin
            div_req.start = 1'b1;
        end else if (r_state == S_SETA) begin
            div_req.start    = 1'b1;
            div_req.dividend = set_sum;
        end else if ((r_state == S_WUSE) && r_fire && !r_del[r_e] && out_load) begin
            div_req.start    = 1'b1;
            div_req.dividend = fire_dl;
        end
    end

    htw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Slot memory port selection.
    always_comb begin
        slot_raddr = r_slot;
        slot_we    = 1'b0;
        slot_waddr = r_slot;
        slot_wdata = '0;
        case (r_state)
            S_CLR: begin
                slot_we    = 1'b1;
                slot_waddr = r_clr;
            end
            S_PLACE: slot_raddr = plc_slot;
            S_CSEL:  slot_raddr = csel_slot;
            S_L1:    slot_raddr = l1_slot;
            S_PLRD: begin
                slot_we    = 1'b1;
                slot_wdata = sr_valid ? {1'b1, sr_head, r_e} : {1'b1, r_e, r_e};
            end
            S_CRD, S_L1RD: slot_we = sr_valid;
            default: ;
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (r_clr == SW'(SLOT_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (t_action'(i_action))
                        ACT_SET: begin
                            if (!free_found) begin
                                n_state = S_RESP;
                            end else if (!r_enabled) begin
                                n_state = S_DIVC;
                            end else begin
                                n_state = S_SETA;
                            end
                        end
                        ACT_TICK: begin
                            if (!r_enabled) begin
                                n_state = S_RESP;
                            end else if (r_cur[LEVEL1_BITS-1:0] == '0) begin
                                n_state = S_CSEL;
                            end else begin
                                n_state = S_L1;
                            end
                        end
                        default: n_state = S_RESP;
                    endcase
                end
            end
            S_DIVC:  if (div_done) n_state = S_SETA;
            S_SETA:  n_state = S_DIVE;
            S_DIVE:  if (div_done) n_state = S_PLACE;
            S_PLACE: n_state = S_PLRD;
            S_PLRD:  n_state = r_ret_set ? S_RESP : S_NEXT;
            S_CSEL:  n_state = S_CRD;
            S_CRD: begin
                if (sr_valid) begin
                    n_state = S_WRD;
                end else if (casc_done) begin
                    n_state = S_L1;
                end else begin
                    n_state = S_CSEL;
                end
            end
            S_L1:    n_state = S_L1RD;
            S_L1RD:  n_state = sr_valid ? S_WRD : S_RESP;
            S_WRD:   n_state = S_WUSE;
            S_WUSE: begin
                if (!r_fire) begin
                    n_state = S_PLACE;
                end else if (r_del[r_e]) begin
                    n_state = S_NEXT;
                end else if (out_load) begin
                    n_state = S_DIVF;
                end
            end
            S_DIVF:  if (div_done) n_state = S_PLACE;
            S_NEXT: begin
                if (!walk_done) begin
                    n_state = S_WRD;
                end else if (r_fire) begin
                    n_state = S_RESP;
                end else if (casc_done) begin
                    n_state = S_L1;
                end else begin
                    n_state = S_CSEL;
                end
            end
            S_RESP:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state: sequencer, configuration, wheel clock, flags, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_period  <= PERIOD_RST;
            r_enabled <= 1'b0;
            r_cur     <= '0;
            r_clr     <= '0;
            r_ov      <= 1'b0;
            for (int i = 0; i < POOL_SIZE; i++) begin
                r_used[i] <= 1'b0;
                r_del[i]  <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
            if (r_state == S_CLR) begin
                r_clr <= r_clr + 1'b1;
            end
            if ((r_state == S_DIVC) && div_done) begin
                r_enabled <= 1'b1;
                r_cur     <= div_q;
            end
            // A tick on an enabled wheel ends with the wheel clock one step on.
            if (((r_state == S_L1RD) && !sr_valid) ||
                ((r_state == S_NEXT) && walk_done && r_fire)) begin
                r_cur <= r_cur + 32'd1;
            end
            if (accept && (t_action'(i_action) == ACT_KILL) && h_ok && r_used[h_idx]) begin
                r_del[h_idx] <= 1'b1;
            end
            if (r_state == S_SETA) begin
                r_used[r_e] <= 1'b1;
                r_del[r_e]  <= 1'b0;
            end
            // A deleted timer is freed when its level-one slot comes up.
            if ((r_state == S_WUSE) && r_fire && r_del[r_e]) begin
                r_used[r_e] <= 1'b0;
                r_del[r_e]  <= 1'b0;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Working registers of the sequencer.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_interval    <= i_interval_ms;
                r_event       <= i_event_id;
                r_dl          <= i_now_ms + i_delay_ms;
                r_e           <= free_idx;
                r_ret_set     <= 1'b1;
                r_lv          <= 2'd0;
                case (t_action'(i_action))
                    ACT_SET: begin
                        r_resp_kind   <= free_found ? KIND_SET : KIND_FULL;
                        r_resp_handle <= 5'd0;
                        r_resp_alive  <= 1'b0;
                    end
                    ACT_KILL: begin
                        r_resp_kind   <= KIND_KILL;
                        r_resp_handle <= i_timer_handle;
                        r_resp_alive  <= 1'b0;
                    end
                    ACT_QUERY: begin
                        r_resp_kind   <= KIND_ALIVE;
                        r_resp_handle <= i_timer_handle;
                        r_resp_alive  <= h_ok && r_used[h_idx] && !r_del[h_idx];
                    end
                    default: begin
                        r_resp_kind   <= KIND_TICK;
                        r_resp_handle <= 5'd0;
                        r_resp_alive  <= 1'b0;
                    end
                endcase
            end
            S_SETA:  r_dl <= set_sum;
            S_DIVE:  if (div_done) r_exp <= div_q;
            S_DIVF:  if (div_done) r_exp <= div_q;
            S_PLRD:  r_resp_handle <= 5'(r_e);
            S_CSEL: begin
                r_slot <= csel_slot;
                r_knz  <= csel_knz;
            end
            S_L1:    r_slot <= l1_slot;
            S_CRD: begin
                r_e       <= sr_head;
                r_tail    <= sr_tail;
                r_cnt     <= '0;
                r_fire    <= 1'b0;
                r_ret_set <= 1'b0;
                if (!sr_valid && !casc_done) begin
                    r_lv <= r_lv + 2'd1;
                end
            end
            S_L1RD: begin
                r_e           <= sr_head;
                r_tail        <= sr_tail;
                r_cnt         <= '0;
                r_fire        <= 1'b1;
                r_ret_set     <= 1'b0;
                r_resp_kind   <= KIND_TICK;
                r_resp_handle <= 5'd0;
            end
            S_WUSE: begin
                r_nx  <= r_rd_link;
                r_end <= (r_e == r_tail);
                if (!r_fire) begin
                    r_exp <= r_rd_exp;
                end
            end
            S_NEXT: begin
                r_e   <= r_nx;
                r_cnt <= r_cnt + 1'b1;
                r_resp_kind   <= KIND_TICK;
                r_resp_handle <= 5'd0;
                if (walk_done && !r_fire && !casc_done) begin
                    r_lv <= r_lv + 2'd1;
                end
            end
            default: ;
        endcase
        if (r_state == S_PLACE) begin
            r_slot <= plc_slot;
        end
    end

    // Slot memory: one write and one registered read a cycle.
    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            m_slot[slot_waddr] <= slot_wdata;
        end
        r_slot_rd <= m_slot[slot_raddr];
    end

    // Entry memories, all read at the current entry.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_PLRD) && sr_valid) begin
            m_link[sr_tail] <= r_e;
        end
        if (((r_state == S_DIVE) || (r_state == S_DIVF)) && div_done) begin
            m_exp[r_e] <= div_q;
        end
        if (r_state == S_SETA) begin
            m_dl[r_e]  <= set_sum;
            m_ev[r_e]  <= r_event;
            m_per[r_e] <= r_interval;
        end else if ((r_state == S_WUSE) && r_fire && !r_del[r_e] && out_load) begin
            m_dl[r_e] <= fire_dl;
        end
        r_rd_link <= m_link[r_e];
        r_rd_exp  <= m_exp[r_e];
        r_rd_dl   <= m_dl[r_e];
        r_rd_ev   <= m_ev[r_e];
        r_rd_per  <= m_per[r_e];
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_okind   <= emit_kind;
            r_oev     <= emit_ev;
            r_ohandle <= emit_handle;
            r_oalive  <= emit_alive;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_ov;
    assign o_kind        = r_okind;
    assign o_fired_event = r_oev;
    assign o_handle_out  = r_ohandle;
    assign o_alive       = r_oalive;
    assign o_last        = (r_okind != KIND_FIRED);

endmodule

### rtl/core/htw_checker.sv
// Port-level checker of the timing wheel core and the bind that attaches it.
// Depends on htw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module htw_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [2:0]         o_kind,
    input logic signed [31:0] o_fired_event,
    input logic [4:0]         o_handle_out,
    input logic               o_alive,
    input logic               o_last
);
    import htw_pkg::*;

    // An accepted item keeps the input side stalled while it is worked on.
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // A stalled result item holds.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_kind) && $stable(o_fired_event) && $stable(o_handle_out))

    // Only fired items are followed by more results of the same item.
    `ASSERT_IMPLY(a_last_kind, i_clk, i_rst_n, o_out_valid, o_last == (o_kind != KIND_FIRED))

    // The alive bit is set only in an alive answer.
    `ASSERT_IMPLY(a_alive_answer, i_clk, i_rst_n, o_out_valid && (o_kind != KIND_ALIVE), !o_alive)

endmodule

bind hierarchical_timing_wheel_core htw_checker u_htw_checker (.*);
